// ===== hdl/twist_acceleration_limiter_unit_macros.svh =====
// assertion macros for the twist acceleration limiter
// used by the controller and top level; no other dependencies
`ifndef TWIST_ACCELERATION_LIMITER_UNIT_MACROS_SVH
`define TWIST_ACCELERATION_LIMITER_UNIT_MACROS_SVH
// assert an implication on the same edge
`define TAL_ASSERT_IMP(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
// assert an implication on the next edge
`define TAL_ASSERT_NXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== hdl/tal_pkg.sv =====
// shared types and constants for the twist acceleration limiter
// no dependencies
package tal_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 31;
  localparam logic [1:0] CfgMode = 2'd0;
  localparam logic [1:0] CfgRate = 2'd1;
  localparam logic [1:0] CfgMaxLin = 2'd2;
  localparam logic [1:0] CfgMaxAng = 2'd3;
  localparam logic [1:0] ModeFree = 2'd1;
  localparam logic [1:0] ModeActive = 2'd2;
  localparam logic [13:0] RateReset = 14'd100;
  localparam logic [30:0] MaxReset = 31'd65536;
  localparam int unsigned SqrtSteps = 34;
  localparam int unsigned DivSteps = 64;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_ACC, ST_DIV, ST_STEP, ST_NEXT, ST_OUT
  } tal_state_e;

  typedef struct packed {
    logic load;
    logic sq_start;
    logic sqrt_step;
    logic acc_calc;
    logic div_init;
    logic div_step;
    logic comp_done;
    logic vec_done;
    logic sel_ang;
    logic [1:0] comp;
  } tal_cmd_t;

  typedef struct packed {
    logic over;
  } tal_sts_t;
endpackage

// ===== hdl/twist_acceleration_limiter_unit.sv =====
// Twist acceleration limiter top level: config registers, controller, datapath.
// Depends on tal_pkg, tal_ctrl, tal_datapath and the macros header.
// In limit mode, per vector a 34-step bit-serial square root always runs; when the
// limit is exceeded, three restoring divisions follow. Freedrive goes straight to
// the output. One item is processed at a time.
`include "twist_acceleration_limiter_unit_macros.svh"
module twist_acceleration_limiter_unit import tal_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [31:0] target_lin_x_i,
  input  logic signed [31:0] target_lin_y_i,
  input  logic signed [31:0] target_lin_z_i,
  input  logic signed [31:0] target_ang_x_i,
  input  logic signed [31:0] target_ang_y_i,
  input  logic signed [31:0] target_ang_z_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic result_kind_o,
  output logic signed [31:0] cmd_lin_x_o,
  output logic signed [31:0] cmd_lin_y_o,
  output logic signed [31:0] cmd_lin_z_o,
  output logic signed [31:0] cmd_ang_x_o,
  output logic signed [31:0] cmd_ang_y_o,
  output logic signed [31:0] cmd_ang_z_o
);
  logic [1:0] mode_q;
  logic [13:0] rate_q;
  logic [30:0] max_lin_q, max_ang_q;
  tal_cmd_t cmd;
  tal_sts_t sts;
  logic signed [31:0] tgt [6];
  logic signed [31:0] prev [6];
  logic kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      rate_q <= RateReset;
      max_lin_q <= MaxReset;
      max_ang_q <= MaxReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode: mode_q <= cfg_data_i[1:0];
        CfgRate: rate_q <= cfg_data_i[13:0];
        CfgMaxLin: max_lin_q <= cfg_data_i;
        CfgMaxAng: max_ang_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tgt = '{target_lin_x_i, target_lin_y_i, target_lin_z_i,
                 target_ang_x_i, target_ang_y_i, target_ang_z_i};

  tal_ctrl u_ctrl (
    .clk_i, .rst_ni, .mode_i(mode_q), .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .kind_o(kind), .sts_i(sts), .cmd_o(cmd)
  );

  tal_datapath u_dp (
    .clk_i, .cmd_i(cmd), .sts_o(sts), .rate_i(rate_q), .max_lin_i(max_lin_q),
    .max_ang_i(max_ang_q), .tgt_i(tgt), .rst_ni, .prev_o(prev)
  );

  assign result_kind_o = kind;
  assign cmd_lin_x_o = kind ? prev[0] : '0;
  assign cmd_lin_y_o = kind ? prev[1] : '0;
  assign cmd_lin_z_o = kind ? prev[2] : '0;
  assign cmd_ang_x_o = kind ? prev[3] : '0;
  assign cmd_ang_y_o = kind ? prev[4] : '0;
  assign cmd_ang_z_o = kind ? prev[5] : '0;

  `TAL_ASSERT_IMP(a_top_kind, clk_i, rst_ni, out_valid_o && !result_kind_o, cmd_lin_x_o == 0)
  `TAL_ASSERT_NXT(a_top_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(cmd_ang_z_o))
  `TAL_ASSERT_IMP(a_top_rdy, clk_i, rst_ni, in_ready_o, !out_valid_o)
endmodule

// ===== hdl/tal_datapath.sv =====
// datapath: difference, norm, shift-subtract square root and divider
// depends on tal_pkg
module tal_datapath import tal_pkg::*; (
  input  logic clk_i,
  input  tal_cmd_t cmd_i,
  output tal_sts_t sts_o,
  input  logic [13:0] rate_i,
  input  logic [30:0] max_lin_i,
  input  logic [30:0] max_ang_i,
  input  logic signed [31:0] tgt_i [6],
  input  logic rst_ni,
  output logic signed [31:0] prev_o [6]
);
  logic signed [31:0] tgt_q [6];
  logic signed [31:0] prev_q [6];
  logic signed [31:0] res_q [3];
  logic [32:0] mag_q [3];
  logic neg_q [3];
  logic [67:0] sum_q;
  logic [67:0] rem_q;
  logic [33:0] root_q;
  logic [5:0] cnt_q;
  logic [47:0] acc_q;
  logic [63:0] num_q;
  logic [63:0] qt_q;
  logic [63:0] drem_q;
  logic [1:0] k_q;

  logic [2:0] b;
  logic [30:0] maxv;
  logic [69:0] trial;
  logic [64:0] dtrial;
  logic signed [33:0] diffv [3];
  logic signed [33:0] stepv;

  assign b = cmd_i.sel_ang ? 3'd3 : 3'd0;
  assign maxv = cmd_i.sel_ang ? max_ang_i : max_lin_i;
  assign sts_o.over = acc_q > {17'd0, maxv};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diffv[i] = 34'(tgt_q[b + 3'(i)]) - 34'(prev_q[b + 3'(i)]);
    end
    trial = {rem_q, sum_q[67:66]} - {34'd0, root_q, 2'b01};
    dtrial = {drem_q, num_q[63]} - {17'd0, acc_q};
    stepv = neg_q[cmd_i.comp] ? -34'(qt_q[32:0]) : 34'(qt_q[32:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_q <= tgt_i;
    end
    if (cmd_i.sq_start) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= diffv[i][33];
        mag_q[i] <= diffv[i][33] ? 33'(-diffv[i]) : 33'(diffv[i]);
        res_q[i] <= tgt_q[b + 3'(i)];
      end
      k_q <= 2'd0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (!cmd_i.sqrt_step && k_q != 2'd3 && cnt_q == 6'd0 && !cmd_i.acc_calc
                 && !cmd_i.div_init && !cmd_i.div_step && !cmd_i.comp_done) begin
      sum_q <= sum_q + 68'({mag_q[k_q]} * {mag_q[k_q]});
      k_q <= k_q + 2'd1;
      rem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      if (!trial[69]) begin
        rem_q <= trial[67:0];
        root_q <= {root_q[32:0], 1'b1};
      end else begin
        rem_q <= {rem_q[65:0], sum_q[67:66]};
        root_q <= {root_q[32:0], 1'b0};
      end
      sum_q <= {sum_q[65:0], 2'b00};
      cnt_q <= cnt_q + 6'd1;
    end
    if (cmd_i.acc_calc) begin
      acc_q <= 48'(root_q) * 48'(rate_i);
      cnt_q <= '0;
    end
    if (cmd_i.div_init) begin
      num_q <= 64'(mag_q[cmd_i.comp]) * 64'(maxv);
      drem_q <= '0;
      qt_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (!dtrial[64]) begin
        drem_q <= dtrial[63:0];
        qt_q <= {qt_q[62:0], 1'b1};
      end else begin
        drem_q <= {drem_q[62:0], num_q[63]};
        qt_q <= {qt_q[62:0], 1'b0};
      end
      num_q <= {num_q[62:0], 1'b0};
    end
    if (cmd_i.comp_done) begin
      res_q[cmd_i.comp] <= 32'(34'(prev_q[b + 3'(cmd_i.comp)]) + stepv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) prev_q[i] <= '0;
    end else if (cmd_i.vec_done) begin
      for (int i = 0; i < 3; i++) prev_q[b + 3'(i)] <= res_q[i];
    end
  end

  assign prev_o = prev_q;
endmodule

// ===== hdl/tal_ctrl.sv =====
// controller state machine sequencing the datapath
// depends on tal_pkg and the macros header
`include "twist_acceleration_limiter_unit_macros.svh"
module tal_ctrl import tal_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [1:0] mode_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic kind_o,
  input  tal_sts_t sts_i,
  output tal_cmd_t cmd_o
);
  tal_state_e state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic ang_q, ang_d;
  logic [1:0] comp_q, comp_d;
  logic kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      ang_q <= 1'b0;
      comp_q <= '0;
      kind_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ang_q <= ang_d;
      comp_q <= comp_d;
      kind_q <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ang_d = ang_q;
    comp_d = comp_q;
    kind_d = kind_q;
    cmd_o = '0;
    cmd_o.sel_ang = ang_q;
    cmd_o.comp = comp_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i == ModeFree) begin
            kind_d = 1'b0;
            state_d = ST_OUT;
          end else if (mode_i == ModeActive) begin
            kind_d = 1'b1;
            cmd_o.load = 1'b1;
            ang_d = 1'b0;
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        cmd_o.sq_start = 1'b1;
        cnt_d = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q >= 7'd3) cmd_o.sqrt_step = 1'b1;
        if (cnt_q == 7'(SqrtSteps + 2)) state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_calc = 1'b1;
        comp_d = '0;
        state_d = ST_DIV;
        cnt_d = '0;
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          if (!sts_i.over) begin
            state_d = ST_NEXT;
          end else begin
            cmd_o.div_init = 1'b1;
            cnt_d = 7'd1;
          end
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d = cnt_q + 7'd1;
          if (cnt_q == 7'(DivSteps)) state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.comp_done = 1'b1;
        cnt_d = 7'd0;
        if (comp_q == 2'd2) begin
          state_d = ST_NEXT;
        end else begin
          comp_d = comp_q + 2'd1;
          cnt_d = 7'd0;
          state_d = ST_DIV;
        end
      end
      ST_NEXT: begin
        cmd_o.vec_done = 1'b1;
        if (ang_q) begin
          state_d = ST_OUT;
        end else begin
          ang_d = 1'b1;
          state_d = ST_SQ;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign kind_o = kind_q;

  `TAL_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `TAL_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `TAL_ASSERT_IMP(a_cmd, clk_i, rst_ni, cmd_o.div_step, !cmd_o.sqrt_step)
endmodule

// ===== sim/tal_checker.sv =====
// Transaction checker for the twist acceleration limiter: snoops config writes and both channels,
// predicts every command from its own copy of registers and previous twist, compares in order.
// Depends on tal_pkg only.
module tal_checker import tal_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic [5:0][31:0] target_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  logic result_kind_i,
  input  logic [5:0][31:0] cmd_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic kind;
    logic [5:0][31:0] cmd;
  } twist_cmd_t;

  logic [1:0] mode_q;
  logic [13:0] rate_q;
  logic [30:0] max_lin_q, max_ang_q;
  logic [5:0][31:0] last_cmd_q;
  twist_cmd_t expected_cmds[$];

  function automatic logic [63:0] floor_sqrt(logic [127:0] s);
    logic [63:0] lo, hi, mid;
    lo = '0;
    hi = 64'd1 << 34;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if ({64'd0, mid} * {64'd0, mid} <= s) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [2:0][31:0] limit_vec(logic [2:0][31:0] tgt, logic [2:0][31:0] prv,
                                                 logic [30:0] max_acc, logic [13:0] rate);
    logic signed [63:0] d[3];
    logic [63:0] m[3];
    logic [127:0] sum;
    logic [63:0] acc, q;
    logic signed [63:0] v;
    logic [2:0][31:0] res;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 64'($signed(tgt[i])) - 64'($signed(prv[i]));
      m[i] = d[i] < 0 ? -d[i] : d[i];
      sum += {64'd0, m[i]} * {64'd0, m[i]};
    end
    acc = floor_sqrt(sum) * {50'd0, rate};
    for (int i = 0; i < 3; i++) begin
      v = 64'($signed(tgt[i]));
      if (acc > {33'd0, max_acc}) begin
        q = (m[i] * {33'd0, max_acc}) / acc;
        v = 64'($signed(prv[i])) + (d[i] < 0 ? -$signed(q) : $signed(q));
      end
      if (v > 64'sd2147483647) res[i] = 32'h7fffffff;
      else if (v < -64'sd2147483648) res[i] = 32'h80000000;
      else res[i] = v[31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int idx, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch %s[%0d]: got %h, expected %h", $time, what, idx, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    twist_cmd_t exp_cmd;
    if (!rst_ni) begin
      mode_q <= '0;
      rate_q <= RateReset;
      max_lin_q <= MaxReset;
      max_ang_q <= MaxReset;
      last_cmd_q <= '0;
      expected_cmds.delete();
      fail_count_o = 0;
      checked_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMode: mode_q <= cfg_data_i[1:0];
          CfgRate: rate_q <= cfg_data_i[13:0];
          CfgMaxLin: max_lin_q <= cfg_data_i;
          CfgMaxAng: max_ang_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (mode_q == ModeFree) begin
          expected_cmds.push_back('0);
        end else if (mode_q == ModeActive) begin
          exp_cmd.kind = 1'b1;
          exp_cmd.cmd[2:0] = limit_vec(target_i[2:0], last_cmd_q[2:0], max_lin_q, rate_q);
          exp_cmd.cmd[5:3] = limit_vec(target_i[5:3], last_cmd_q[5:3], max_ang_q, rate_q);
          last_cmd_q <= exp_cmd.cmd;
          expected_cmds.push_back(exp_cmd);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected result kind", 0, 32'(result_kind_i), 0);
        end else begin
          exp_cmd = expected_cmds.pop_front();
          checked_o <= checked_o + 1;
          if (result_kind_i !== exp_cmd.kind)
            report_mismatch("result_kind", 0, 32'(result_kind_i), 32'(exp_cmd.kind));
          for (int i = 0; i < 6; i++)
            if (cmd_i[i] !== exp_cmd.cmd[i]) report_mismatch("cmd", i, cmd_i[i], exp_cmd.cmd[i]);
        end
      end
      pending_o <= expected_cmds.size();
    end
  end
endmodule

// ===== sim/tb_twist_acceleration_limiter_unit.sv =====
// Testbench top for twist_acceleration_limiter_unit: clock, reset, config writes, stimulus.
// Depends on tal_pkg, the block and tal_checker, which does all prediction and comparison.
module tb_twist_acceleration_limiter_unit import tal_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 400;
  localparam int CycleLimit = 3000000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, result_kind_o;
  logic [5:0][31:0] target, cmd;
  int fail_count, pending, checked;
  int send_idle_pct, recv_stall_pct, hold_cycles, items_sent, cycles;
  logic [5:0][31:0] last_target;

  twist_acceleration_limiter_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .target_lin_x_i(target[0]), .target_lin_y_i(target[1]), .target_lin_z_i(target[2]),
    .target_ang_x_i(target[3]), .target_ang_y_i(target[4]), .target_ang_z_i(target[5]),
    .out_valid_o, .out_ready_i, .result_kind_o,
    .cmd_lin_x_o(cmd[0]), .cmd_lin_y_o(cmd[1]), .cmd_lin_z_o(cmd[2]),
    .cmd_ang_x_o(cmd[3]), .cmd_ang_y_o(cmd[4]), .cmd_ang_z_o(cmd[5])
  );

  tal_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .target_i(target),
    .out_valid_i(out_valid_o), .out_ready_i, .result_kind_i(result_kind_o), .cmd_i(cmd),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall, with long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send(logic [5:0][31:0] t);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    target <= t;
    last_target = t;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_all(logic [31:0] v);
    send({6{v}});
  endtask

  function automatic logic [5:0][31:0] random_target();
    logic [5:0][31:0] t;
    int pick;
    logic [31:0] extremes[4];
    extremes = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
    pick = $urandom_range(9);
    for (int i = 0; i < 6; i++) begin
      case (pick)
        0, 1, 2, 3, 4: t[i] = last_target[i] + $urandom_range(4000) - 2000;
        5, 6: t[i] = $urandom;
        7: t[i] = extremes[$urandom_range(3)];
        default: t[i] = last_target[i] + ($signed($urandom) >>> 12);
      endcase
    end
    return t;
  endfunction

  task automatic set_limits(logic [13:0] rate, logic [30:0] max_lin, logic [30:0] max_ang);
    cfg_write(CfgRate, 31'(rate));
    cfg_write(CfgMaxLin, max_lin);
    cfg_write(CfgMaxAng, max_ang);
  endtask

  initial begin
    logic [1:0] mode_sel;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    target <= '0;
    out_ready_i <= 1'b0;
    cycles <= 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    last_target = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default limits, then edge settings
    cfg_write(CfgMode, 31'(ModeActive));
    send('0);
    send({32'd0, 32'd0, 32'd300, 32'd0, 32'd0, 32'd100});
    send_all(32'h7fffffff);
    send_all(32'h80000000);
    send({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
    send_all(32'hffffffff);
    send({32'd1, 32'd0, 32'd0, 32'hfff00000, 32'd0, 32'd0});
    drain();
    set_limits(14'd0, 31'h7fffffff, 31'h7fffffff);
    send_all(32'h7fffffff);
    send_all(32'h80000000);
    drain();
    set_limits(14'h3fff, 31'd0, 31'd0);
    send_all(32'h12345678);
    send('0);
    drain();
    set_limits(14'd1, 31'h7fffffff, 31'd1);
    send_all(32'h80000000);
    send_all(32'h7fffffff);
    drain();
    cfg_write(CfgMode, 31'(ModeFree));
    send_all(32'h55555555);
    send_all(32'haaaaaaaa);
    drain();
    cfg_write(CfgMode, 31'd3);
    send_all(32'h0f0f0f0f);
    drain();
    cfg_write(CfgMode, 31'd0);
    send_all(32'hf0f0f0f0);
    drain();

    // random phases over settings and idling patterns
    for (int p = 0; p < 10; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 86; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 86; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      case (p)
        0: set_limits(RateReset, MaxReset, MaxReset);
        1: set_limits(14'd10000, 31'h7fffffff, 31'd1000);
        2: set_limits(14'd1, 31'd0, 31'h7fffffff);
        4: set_limits(14'h3fff, 31'd65536, 31'd131072);
        5: set_limits(14'd0, 31'd7, 31'd7);
        default: set_limits(14'($urandom_range(10000, 1)), 31'($urandom), 31'($urandom));
      endcase
      mode_sel = (p == 3) ? ModeFree : (p == 7) ? 2'd0 : ModeActive;
      cfg_write(CfgMode, 31'(mode_sel));
      for (int i = 0; i < ((p == 7) ? 20 : 160); i++) begin
        if (p == 6 && i == 40) hold_cycles = 3000;
        send(random_target());
      end
      drain();
    end

    $display("covered %0d input transactions across idle, freedrive and limiting modes",
             items_sent);
    $display("%0d result transactions checked under varied rates, limits and stalls", checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
